// ===== sv/imu_bcd_frame_parser_core_defines.svh =====
// Assertion macros shared by the IMU BCD frame parser RTL.
`ifndef IMU_BCD_FRAME_PARSER_CORE_DEFINES_SVH
`define IMU_BCD_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define IMU_BCD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset
`define IMU_BCD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/imu_bcd_pkg.sv =====
// Types, constants and helper functions for the IMU BCD frame parser.
package imu_bcd_pkg;

    localparam int FRAME_BYTES      = 48;
    localparam int ADDR_W           = $clog2(FRAME_BYTES);
    localparam int FIRST_FIELD_BYTE = 4;
    localparam int NUM_FIELDS       = 13;
    localparam int FIELD_IDX_W      = 4;
    localparam int VALUE_W          = 25;
    localparam int STATUS_W         = 2;
    localparam int ACC_W            = 27;
    localparam int VALUE_LIMIT      = 9999999;

    // Accel fields are scaled, quaternion fields carry four digit pairs
    localparam int ACCEL_FIRST = 3;
    localparam int ACCEL_LAST  = 5;
    localparam int QUAT_FIRST  = 9;

    localparam logic [7:0] DEV_ADDR_RESET = 8'h77;
    localparam logic [7:0] HDR_B1         = 8'h2f;
    localparam logic [7:0] HDR_B2         = 8'h00;
    localparam logic [7:0] HDR_B3         = 8'h59;

    // Byte offset of the first digit pair of each field
    localparam logic [ADDR_W-1:0] FIELD_POS [NUM_FIELDS] = '{
        6'd4, 6'd7, 6'd10, 6'd13, 6'd16, 6'd19, 6'd22, 6'd25, 6'd28,
        6'd31, 6'd35, 6'd39, 6'd43
    };

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_CHECKSUM = 2'd1,
        STATUS_DIGIT    = 2'd2
    } status_t;

    // One packed-BCD byte as a value 0..99 (upper nibble times ten plus lower)
    function automatic logic [6:0] bcd_pair(input logic [7:0] b);
        logic [6:0] hi;
        logic [6:0] lo;
        hi = {3'b000, b[7:4]};
        lo = {3'b000, b[3:0]};
        return (hi << 3) + (hi << 1) + lo;
    endfunction

    // True when either nibble is not a decimal digit
    function automatic logic nibble_bad(input logic [7:0] b);
        return (b[7:4] > 4'd9) || (b[3:0] > 4'd9);
    endfunction

endpackage

// ===== sv/imu_bcd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module imu_bcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write on enable, read every cycle
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/imu_bcd_frame_parser_core.sv =====
// Top level of the IMU BCD frame parser: header hunt, checksum and field decode.
//
// Bytes from the serial link are taken one per cycle while the parser hunts for the header
// (device address, 0x2f, 0x00, 0x59) and collects a 48-byte frame into a small RAM. On the
// final byte the checksum (low 8 bits of the sum of bytes 1 to 46 against byte 47) is checked.
// A bad checksum or a non-decimal nibble gives one error item with last set, once the output
// register is free. A good frame gives 13 signed fixed-point items, field 0 to 12, the last
// one marked. These are decoded by one shared multiply-by-100 accumulator that reads the digit
// pairs from the RAM's single registered read port, a FETCH and an ACCUM state per pair (three
// pairs per field, four for quaternion fields, SCALE after the accel fields). A good frame's
// final byte keeps s_ready low until its last item is loaded, also while the result side
// stalls. The device address register may be written whenever the parser is idle.
module imu_bcd_frame_parser_core (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      cfg_wr_en,
    input  logic [7:0]                                cfg_wr_data,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic [7:0]                                s_rx_byte,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic [imu_bcd_pkg::FIELD_IDX_W-1:0]       m_field_index,
    output logic signed [imu_bcd_pkg::VALUE_W-1:0]    m_value,
    output logic [imu_bcd_pkg::STATUS_W-1:0]          m_status,
    output logic                                      m_last
);

`include "imu_bcd_frame_parser_core_defines.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ACCUM,
        ST_SCALE,
        ST_OUT
    } state_t;

    state_t                                   state_reg, state_next;
    logic [7:0]                               dev_addr_reg, dev_addr_next;
    logic [imu_bcd_pkg::ADDR_W-1:0]           pos_reg, pos_next;
    logic [7:0]                               sum_reg, sum_next;
    logic                                     derr_reg, derr_next;
    logic [imu_bcd_pkg::FIELD_IDX_W-1:0]      field_reg, field_next;
    logic [1:0]                               digit_reg, digit_next;
    logic [imu_bcd_pkg::ACC_W-1:0]            acc_reg, acc_next;
    logic                                     neg_reg, neg_next;
    logic                                     err_reg, err_next;
    imu_bcd_pkg::status_t                     err_status_reg, err_status_next;
    logic                                     m_valid_reg, m_valid_next;
    logic [imu_bcd_pkg::FIELD_IDX_W-1:0]      m_field_index_reg, m_field_index_next;
    logic signed [imu_bcd_pkg::VALUE_W-1:0]   m_value_reg, m_value_next;
    imu_bcd_pkg::status_t                     m_status_reg, m_status_next;
    logic                                     m_last_reg, m_last_next;

    logic                                     hdr_ok;
    logic                                     ram_wr_en;
    logic [imu_bcd_pkg::ADDR_W-1:0]           ram_wr_addr;
    logic [imu_bcd_pkg::ADDR_W-1:0]           rd_addr;
    logic [7:0]                               rd_data;
    logic [6:0]                               pair;
    logic [1:0]                               last_digit;
    logic                                     scaled;
    logic                                     out_free;
    logic [imu_bcd_pkg::ACC_W-1:0]            acc_x100;
    logic [imu_bcd_pkg::ACC_W-1:0]            acc_x98;
    logic [imu_bcd_pkg::ACC_W-1:0]            sat;
    logic signed [imu_bcd_pkg::VALUE_W-1:0]   mag;

    imu_bcd_ram #(
        .WIDTH (8),
        .DEPTH (imu_bcd_pkg::FRAME_BYTES)
    ) u_frame_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (s_rx_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Compare the incoming byte against the header byte expected at this position
    always_comb begin
        case (pos_reg)
            imu_bcd_pkg::ADDR_W'(0): hdr_ok = (s_rx_byte == dev_addr_reg);
            imu_bcd_pkg::ADDR_W'(1): hdr_ok = (s_rx_byte == imu_bcd_pkg::HDR_B1);
            imu_bcd_pkg::ADDR_W'(2): hdr_ok = (s_rx_byte == imu_bcd_pkg::HDR_B2);
            imu_bcd_pkg::ADDR_W'(3): hdr_ok = (s_rx_byte == imu_bcd_pkg::HDR_B3);
            default:                 hdr_ok = 1'b1;
        endcase
    end

    // Shared arithmetic: digit pair, multiply by 100 and by 98, saturate and sign
    assign rd_addr    = imu_bcd_pkg::FIELD_POS[field_reg] + imu_bcd_pkg::ADDR_W'(digit_reg);
    assign pair       = imu_bcd_pkg::bcd_pair(rd_data);
    assign last_digit = (field_reg >= imu_bcd_pkg::FIELD_IDX_W'(imu_bcd_pkg::QUAT_FIRST))
                        ? 2'd3 : 2'd2;
    assign scaled     = (field_reg >= imu_bcd_pkg::FIELD_IDX_W'(imu_bcd_pkg::ACCEL_FIRST)) &&
                        (field_reg <= imu_bcd_pkg::FIELD_IDX_W'(imu_bcd_pkg::ACCEL_LAST));
    assign acc_x100   = (acc_reg << 6) + (acc_reg << 5) + (acc_reg << 2);
    assign acc_x98    = (acc_reg << 7) - (acc_reg << 5) + (acc_reg << 1);
    assign sat        = (acc_reg > imu_bcd_pkg::ACC_W'(imu_bcd_pkg::VALUE_LIMIT))
                        ? imu_bcd_pkg::ACC_W'(imu_bcd_pkg::VALUE_LIMIT) : acc_reg;
    assign mag        = imu_bcd_pkg::VALUE_W'(sat);
    assign out_free   = !m_valid_reg || m_ready;

    // Sequencer: collect bytes, then walk the fields one digit pair at a time
    always_comb begin
        state_next         = state_reg;
        dev_addr_next      = cfg_wr_en ? cfg_wr_data : dev_addr_reg;
        pos_next           = pos_reg;
        sum_next           = sum_reg;
        derr_next          = derr_reg;
        field_next         = field_reg;
        digit_next         = digit_reg;
        acc_next           = acc_reg;
        neg_next           = neg_reg;
        err_next           = err_reg;
        err_status_next    = err_status_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_field_index_next = m_field_index_reg;
        m_value_next       = m_value_reg;
        m_status_next      = m_status_reg;
        m_last_next        = m_last_reg;
        ram_wr_en          = 1'b0;
        ram_wr_addr        = pos_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!hdr_ok) begin
                        // Restart the hunt, reusing the byte if it is a device address
                        sum_next  = '0;
                        derr_next = 1'b0;
                        if (s_rx_byte == dev_addr_reg) begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = '0;
                            pos_next    = imu_bcd_pkg::ADDR_W'(1);
                        end else begin
                            pos_next = '0;
                        end
                    end else begin
                        ram_wr_en = 1'b1;
                        if (pos_reg != imu_bcd_pkg::ADDR_W'(imu_bcd_pkg::FRAME_BYTES - 1)) begin
                            if (pos_reg != '0) begin
                                sum_next = sum_reg + s_rx_byte;
                            end
                            if (pos_reg >= imu_bcd_pkg::ADDR_W'(imu_bcd_pkg::FIRST_FIELD_BYTE) &&
                                imu_bcd_pkg::nibble_bad(s_rx_byte)) begin
                                derr_next = 1'b1;
                            end
                            pos_next = pos_reg + 1'b1;
                        end else begin
                            // Final byte: check the sum, then report or decode
                            pos_next   = '0;
                            sum_next   = '0;
                            derr_next  = 1'b0;
                            field_next = '0;
                            digit_next = '0;
                            if (sum_reg != s_rx_byte) begin
                                err_next        = 1'b1;
                                err_status_next = imu_bcd_pkg::STATUS_CHECKSUM;
                                state_next      = ST_OUT;
                            end else if (derr_reg) begin
                                err_next        = 1'b1;
                                err_status_next = imu_bcd_pkg::STATUS_DIGIT;
                                state_next      = ST_OUT;
                            end else begin
                                err_next   = 1'b0;
                                state_next = ST_FETCH;
                            end
                        end
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (digit_reg == '0) begin
                    // A leading pair of ten or more marks a negative value
                    neg_next = (pair >= 7'd10);
                    acc_next = (pair >= 7'd10) ? imu_bcd_pkg::ACC_W'(pair - 7'd10)
                                               : imu_bcd_pkg::ACC_W'(pair);
                end else begin
                    acc_next = acc_x100 + imu_bcd_pkg::ACC_W'(pair);
                end
                if (digit_reg == last_digit) begin
                    state_next = scaled ? ST_SCALE : ST_OUT;
                end else begin
                    digit_next = digit_reg + 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_SCALE: begin
                acc_next   = acc_x98;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Load the output register once it is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (err_reg) begin
                        m_field_index_next = '0;
                        m_value_next       = '0;
                        m_status_next      = err_status_reg;
                        m_last_next        = 1'b1;
                        state_next         = ST_IDLE;
                    end else begin
                        m_field_index_next = field_reg;
                        m_value_next       = neg_reg ? -mag : mag;
                        m_status_next      = imu_bcd_pkg::STATUS_OK;
                        if (field_reg == imu_bcd_pkg::FIELD_IDX_W'(imu_bcd_pkg::NUM_FIELDS - 1))
                        begin
                            m_last_next = 1'b1;
                            state_next  = ST_IDLE;
                        end else begin
                            m_last_next = 1'b0;
                            field_next  = field_reg + 1'b1;
                            digit_next  = '0;
                            state_next  = ST_FETCH;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            dev_addr_reg <= imu_bcd_pkg::DEV_ADDR_RESET;
            pos_reg      <= '0;
            sum_reg      <= '0;
            derr_reg     <= 1'b0;
            field_reg    <= '0;
            digit_reg    <= '0;
            err_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            dev_addr_reg <= dev_addr_next;
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            derr_reg     <= derr_next;
            field_reg    <= field_next;
            digit_reg    <= digit_next;
            err_reg      <= err_next;
            m_valid_reg  <= m_valid_next;
        end
        acc_reg           <= acc_next;
        neg_reg           <= neg_next;
        err_status_reg    <= err_status_next;
        m_field_index_reg <= m_field_index_next;
        m_value_reg       <= m_value_next;
        m_status_reg      <= m_status_next;
        m_last_reg        <= m_last_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_field_index = m_field_index_reg;
    assign m_value       = m_value_reg;
    assign m_status      = m_status_reg;
    assign m_last        = m_last_reg;

    // Checks
    `IMU_BCD_ASSERT_IMP(a_error_is_lone, aclk, aresetn, m_valid && (m_status != imu_bcd_pkg::STATUS_OK), m_last && (m_field_index == '0) && (m_value == '0), "error item must be a lone last item with zero payload")
    `IMU_BCD_ASSERT_IMP(a_value_bounded, aclk, aresetn, m_valid && (m_status == imu_bcd_pkg::STATUS_OK), (m_value <= 25'sd9999999) && (m_value >= -25'sd9999999), "field value outside saturation limits")
    `IMU_BCD_ASSERT_IMP(a_read_in_frame, aclk, aresetn, state_reg == ST_FETCH, rd_addr <= imu_bcd_pkg::ADDR_W'(imu_bcd_pkg::FRAME_BYTES - 2), "digit read beyond the field bytes")
    `IMU_BCD_ASSERT_IMP(a_pos_in_frame, aclk, aresetn, 1'b1, pos_reg < imu_bcd_pkg::ADDR_W'(imu_bcd_pkg::FRAME_BYTES), "byte position beyond frame length")
    `IMU_BCD_ASSERT_NEXT(a_decode_starts, aclk, aresetn, s_valid && s_ready && hdr_ok && (pos_reg == imu_bcd_pkg::ADDR_W'(imu_bcd_pkg::FRAME_BYTES - 1)) && (sum_reg == s_rx_byte) && !derr_reg, (state_reg == ST_FETCH) && (field_reg == '0) && (digit_reg == '0), "good frame did not start decode at the first field")

endmodule
